@@ rtl/mcd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package mcd_pkg;

  localparam logic [7:0] SpaceChar = 8'h20;
  localparam logic [7:0] SlashChar = 8'h2F;
  localparam logic [7:0] DotChar   = 8'h2E;
  localparam logic [7:0] DashChar  = 8'h2D;
  localparam logic [7:0] NoChar    = 8'h00;

  localparam int unsigned CodeMaxSymbols = 6;
  localparam logic [2:0]  LengthSaturate = 3'd7;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef struct packed {
    logic [7:0] symbol;
    logic       end_of_text;
  } in_word_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last_of_text;
  } out_word_t;

  typedef struct packed {
    logic       emit_char;
    logic       emit_space;
    logic       last;
    logic       invalid;
    logic [2:0] length;
    logic [5:0] pattern;
  } task_t;

  function automatic logic [7:0] lookup_code(logic invalid, logic [2:0] length,
                                             logic [5:0] pattern);
    logic [7:0] ch;
    ch = NoChar;
    unique case ({length, pattern})
      {3'd1, 6'b000000}: ch = "e";
      {3'd1, 6'b000001}: ch = "t";
      {3'd2, 6'b000001}: ch = "a";
      {3'd2, 6'b000000}: ch = "i";
      {3'd2, 6'b000011}: ch = "m";
      {3'd2, 6'b000010}: ch = "n";
      {3'd3, 6'b000100}: ch = "d";
      {3'd3, 6'b000110}: ch = "g";
      {3'd3, 6'b000101}: ch = "k";
      {3'd3, 6'b000111}: ch = "o";
      {3'd3, 6'b000010}: ch = "r";
      {3'd3, 6'b000000}: ch = "s";
      {3'd3, 6'b000001}: ch = "u";
      {3'd3, 6'b000011}: ch = "w";
      {3'd4, 6'b001000}: ch = "b";
      {3'd4, 6'b001010}: ch = "c";
      {3'd4, 6'b000010}: ch = "f";
      {3'd4, 6'b000000}: ch = "h";
      {3'd4, 6'b000111}: ch = "j";
      {3'd4, 6'b000100}: ch = "l";
      {3'd4, 6'b000110}: ch = "p";
      {3'd4, 6'b001101}: ch = "q";
      {3'd4, 6'b000001}: ch = "v";
      {3'd4, 6'b001001}: ch = "x";
      {3'd4, 6'b001011}: ch = "y";
      {3'd4, 6'b001100}: ch = "z";
      {3'd5, 6'b011111}: ch = "0";
      {3'd5, 6'b001111}: ch = "1";
      {3'd5, 6'b000111}: ch = "2";
      {3'd5, 6'b000011}: ch = "3";
      {3'd5, 6'b000001}: ch = "4";
      {3'd5, 6'b000000}: ch = "5";
      {3'd5, 6'b010000}: ch = "6";
      {3'd5, 6'b011000}: ch = "7";
      {3'd5, 6'b011100}: ch = "8";
      {3'd5, 6'b011110}: ch = "9";
      {3'd6, 6'b010101}: ch = ".";
      {3'd6, 6'b110011}: ch = ",";
      {3'd6, 6'b001100}: ch = "?";
      {3'd6, 6'b101011}: ch = "!";
      default:           ch = NoChar;
    endcase
    if (invalid) begin
      ch = NoChar;
    end
    return ch;
  endfunction

endpackage
`default_nettype wire

@@ rtl/morse_code_decoder_core.sv @@
// Decodes Morse text given one ASCII byte per word into characters. A byte is
// taken every cycle while full is low. Dots, dashes and any other byte build the
// pending code; a space or slash emits the decoded character of a pending code
// and then a space, and a byte marked end_of_text flushes the pending code. The
// front end keeps the pending code and hands finished tasks to a two-entry task
// queue; the back end looks each task up and drives a result register that
// delivers one word per cycle while pop is high and a task is queued. A
// separator after a pending code yields two words, so the result register sets
// the sustained rate. The first result word of a byte passes through the task
// queue and then the result register before it appears on the output.
`timescale 1ns / 1ps
`default_nettype none
module morse_code_decoder_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push,
  input  wire mcd_pkg::in_word_t  in_word_i,
  output logic                    full,
  output logic                    empty,
  input  wire logic               pop,
  output mcd_pkg::out_word_t      out_word_o
);
  import mcd_pkg::*;

  logic  q_push;
  logic  q_full;
  logic  q_pop;
  logic  q_empty;
  task_t q_task;
  task_t q_head;

  mcd_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .in_word_i (in_word_i),
    .full_o    (full),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_task_o  (q_task)
  );

  mcd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .task_i  (q_task),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .head_o  (q_head)
  );

  mcd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_head_i   (q_head),
    .q_pop_o    (q_pop),
    .empty_o    (empty),
    .pop_i      (pop),
    .out_word_o (out_word_o)
  );

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("Task pushed into a full queue.");

  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("Task popped from an empty queue.");

  a_task_emits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> (q_task.emit_char || q_task.emit_space))
    else $error("Queued task produces no word.");

  a_space_task_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_push && !q_task.emit_space) |-> (q_task.last && q_task.emit_char))
    else $error("Code flush task is not marked as end of text.");

endmodule
`default_nettype wire

@@ rtl/mcd_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module mcd_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire mcd_pkg::in_word_t in_word_i,
  output logic                  full_o,
  input  wire logic             q_full_i,
  output logic                  q_push_o,
  output mcd_pkg::task_t        q_task_o
);
  import mcd_pkg::*;

  logic [5:0] pattern_q, pattern_d;
  logic [2:0] length_q, length_d;
  logic       invalid_q, invalid_d;

  logic       accept;
  logic       is_sep;
  logic [5:0] pattern_new;
  logic [2:0] length_new;
  logic       invalid_new;

  assign full_o = q_full_i;
  assign accept = push_i && !q_full_i;
  assign is_sep = (in_word_i.symbol == SpaceChar) || (in_word_i.symbol == SlashChar);

  always_comb begin
    pattern_new = pattern_q;
    if (32'(length_q) < CodeMaxSymbols) begin
      pattern_new = {pattern_q[4:0], (in_word_i.symbol == DashChar)};
    end
    length_new  = (length_q < LengthSaturate) ? length_q + 3'd1 : length_q;
    invalid_new = invalid_q ||
                  !((in_word_i.symbol == DotChar) || (in_word_i.symbol == DashChar));
  end

  always_comb begin
    pattern_d = pattern_q;
    length_d  = length_q;
    invalid_d = invalid_q;
    q_push_o  = 1'b0;
    q_task_o  = '0;
    if (accept) begin
      if (is_sep) begin
        q_push_o            = 1'b1;
        q_task_o.emit_char  = (length_q != 3'd0);
        q_task_o.emit_space = 1'b1;
        q_task_o.last       = in_word_i.end_of_text;
        q_task_o.invalid    = invalid_q;
        q_task_o.length     = length_q;
        q_task_o.pattern    = pattern_q;
        pattern_d           = '0;
        length_d            = '0;
        invalid_d           = 1'b0;
      end else if (in_word_i.end_of_text) begin
        q_push_o            = 1'b1;
        q_task_o.emit_char  = 1'b1;
        q_task_o.emit_space = 1'b0;
        q_task_o.last       = 1'b1;
        q_task_o.invalid    = invalid_new;
        q_task_o.length     = length_new;
        q_task_o.pattern    = pattern_new;
        pattern_d           = '0;
        length_d            = '0;
        invalid_d           = 1'b0;
      end else begin
        pattern_d = pattern_new;
        length_d  = length_new;
        invalid_d = invalid_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= '0;
      length_q  <= '0;
      invalid_q <= 1'b0;
    end else begin
      pattern_q <= pattern_d;
      length_q  <= length_d;
      invalid_q <= invalid_d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/mcd_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
module mcd_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire mcd_pkg::task_t task_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                empty_o,
  output mcd_pkg::task_t      head_o
);
  import mcd_pkg::*;

  task_t            mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] count_q, count_d;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (count_q == QCntW'(QDepth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + QPtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + QPtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + QCntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= task_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/mcd_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
module mcd_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           q_empty_i,
  input  wire mcd_pkg::task_t q_head_i,
  output logic                q_pop_o,
  output logic                empty_o,
  input  wire logic           pop_i,
  output mcd_pkg::out_word_t  out_word_o
);
  import mcd_pkg::*;

  out_word_t out_q, out_d;
  logic      out_valid_q, out_valid_d;
  logic      phase_q, phase_d;
  logic      load_en;

  assign load_en    = !out_valid_q || pop_i;
  assign empty_o    = !out_valid_q;
  assign out_word_o = out_q;

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q && !pop_i;
    phase_d     = phase_q;
    q_pop_o     = 1'b0;
    if (load_en && !q_empty_i) begin
      out_valid_d = 1'b1;
      if (q_head_i.emit_char && !phase_q) begin
        out_d.character    = lookup_code(q_head_i.invalid, q_head_i.length,
                                         q_head_i.pattern);
        out_d.last_of_text = q_head_i.last && !q_head_i.emit_space;
        if (q_head_i.emit_space) begin
          phase_d = 1'b1;
        end else begin
          q_pop_o = 1'b1;
        end
      end else begin
        out_d.character    = SpaceChar;
        out_d.last_of_text = q_head_i.last;
        phase_d            = 1'b0;
        q_pop_o            = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      phase_q     <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      phase_q     <= phase_d;
    end
  end

endmodule
`default_nettype wire

@@ bench/tb.sv @@
`timescale 1ns / 1ps
module tb;
  import mcd_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int HoldCycles = 300;

  class decode_sb;
    string codes[40] = '{".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....",
                         "..", ".---", "-.-", ".-..", "--", "-.", "---", ".--.",
                         "--.-", ".-.", "...", "-", "..-", "...-", ".--", "-..-",
                         "-.--", "--..", "-----", ".----", "..---", "...--",
                         "....-", ".....", "-....", "--...", "---..", "----.",
                         ".-.-.-", "--..--", "..--..", "-.-.--"};
    string glyphs = "abcdefghijklmnopqrstuvwxyz0123456789.,?!";
    logic [5:0] pattern;
    logic [2:0] length;
    logic invalid;
    out_word_t expected_q[$];
    int errors;

    function new();
      clear_code();
      errors = 0;
    endfunction

    function void clear_code();
      pattern = '0;
      length = '0;
      invalid = 1'b0;
    endfunction

    function logic [7:0] char_of();
      int n;
      logic [5:0] p;
      if (invalid || length == 0 || length > CodeMaxSymbols) begin
        return NoChar;
      end
      for (int i = 0; i < 40; i++) begin
        n = 0;
        p = '0;
        while (n < codes[i].len() && n < CodeMaxSymbols) begin
          p = {p[4:0], codes[i][n] == "-"};
          n++;
        end
        if (n == length && p == pattern) begin
          return glyphs[i];
        end
      end
      return NoChar;
    endfunction

    function void note_word(in_word_t w);
      out_word_t res[$];
      out_word_t r;
      r.last_of_text = 1'b0;
      if (w.symbol == SpaceChar || w.symbol == SlashChar) begin
        if (length != 0) begin
          r.character = char_of();
          res.push_back(r);
        end
        clear_code();
        r.character = SpaceChar;
        res.push_back(r);
      end else begin
        if (w.symbol != DotChar && w.symbol != DashChar) begin
          invalid = 1'b1;
        end
        if (length < CodeMaxSymbols) begin
          pattern = {pattern[4:0], w.symbol == DashChar};
        end
        if (length < LengthSaturate) begin
          length++;
        end
      end
      if (w.end_of_text) begin
        if (length != 0) begin
          r.character = char_of();
          res.push_back(r);
        end
        if (res.size() > 0) begin
          res[$].last_of_text = 1'b1;
        end
        clear_code();
      end
      foreach (res[i]) begin
        expected_q.push_back(res[i]);
      end
    endfunction

    function void check_word(out_word_t got);
      out_word_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected word, expected none, got char %h last %b",
                 $time, got.character, got.last_of_text);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.character !== want.character || got.last_of_text !== want.last_of_text) begin
        $display("%0t: mismatch, expected char %h last %b, got char %h last %b",
                 $time, want.character, want.last_of_text, got.character,
                 got.last_of_text);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  in_word_t in_word = '0;
  logic full;
  logic empty;
  logic pop;
  out_word_t out_word_o;

  decode_sb sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int words_sent = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int cycle_count = 0;

  morse_code_decoder_core i_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .push(push),
    .in_word_i(in_word),
    .full(full),
    .empty(empty),
    .pop(pop),
    .out_word_o(out_word_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      sb.check_word(out_word_o);
    end
  end

  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop = 1'b0;
      end else begin
        pop = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_word(in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      push = 1'b0;
      @(negedge clk_i);
    end
    push = 1'b1;
    in_word = w;
    @(posedge clk_i);
    while (full) begin
      @(posedge clk_i);
    end
    sb.note_word(w);
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_text(string s, bit last);
    in_word_t w;
    for (int i = 0; i < s.len(); i++) begin
      w.symbol = s[i];
      w.end_of_text = last && (i == s.len() - 1);
      send_word(w);
    end
  endtask

  task automatic send_byte(logic [7:0] b, bit last);
    in_word_t w;
    w.symbol = b;
    w.end_of_text = last;
    send_word(w);
  endtask

  task automatic wait_drained();
    push = 1'b0;
    while (sb.expected_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (4) @(negedge clk_i);
  endtask

  // Mostly well-formed texts: table codes, random dot/dash runs, codes with a
  // foreign byte, doubled separators. A tenth of the texts are raw noise.
  task automatic send_random_text();
    in_word_t text_q[$];
    in_word_t w;
    string s;
    int n_codes;
    int kind;
    logic [7:0] b;
    w.end_of_text = 1'b0;
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 8)) begin
        w.symbol = 8'($urandom_range(255));
        w.end_of_text = ($urandom_range(7) == 0);
        text_q.push_back(w);
      end
    end else begin
      n_codes = $urandom_range(1, 6);
      repeat (n_codes) begin
        kind = $urandom_range(99);
        s = "";
        if (kind < 65 || (kind >= 90 && kind < 97)) begin
          s = sb.codes[$urandom_range(39)];
        end else if (kind < 90) begin
          repeat ($urandom_range(1, 9)) begin
            if ($urandom_range(1)) begin
              s = {s, "-"};
            end else begin
              s = {s, "."};
            end
          end
        end
        for (int i = 0; i < s.len(); i++) begin
          w.symbol = s[i];
          text_q.push_back(w);
        end
        if (kind >= 90 && kind < 97) begin
          do begin
            b = 8'($urandom_range(255));
          end while (b == SpaceChar || b == SlashChar);
          w.symbol = b;
          text_q.insert(text_q.size() - $urandom_range(0, s.len()), w);
        end
        w.symbol = $urandom_range(1) ? SpaceChar : SlashChar;
        text_q.push_back(w);
      end
      if ($urandom_range(1) && text_q.size() > 1 && text_q[$-1].symbol != SpaceChar &&
          text_q[$-1].symbol != SlashChar) begin
        void'(text_q.pop_back());
      end
      text_q[$].end_of_text = 1'b1;
    end
    foreach (text_q[i]) begin
      send_word(text_q[i]);
    end
  endtask

  task automatic run_phase(int send_pct, int recv_pct, int goal);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    while (words_sent < goal) begin
      send_random_text();
    end
    wait_drained();
  endtask

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_text(" ", 1'b0);
    send_text(".", 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_text("/", 1'b0);
    send_text("-.-.--", 1'b1);
    send_text("--------", 1'b0);
    send_text("/", 1'b1);
    send_text("..--. ", 1'b0);
    wait_drained();

    run_phase(33, 70, 600);
    run_phase(70, 33, 1200);
    hold_reqs++;
    run_phase(0, 0, 1780);

    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/mcd_pkg.sv
rtl/mcd_front.sv
rtl/mcd_queue.sv
rtl/mcd_back.sv
rtl/morse_code_decoder_core.sv
bench/tb.sv
